// File: rtl/keyed_byte_stream_decrypt_defines.svh
// Assertion macros shared by the decrypt block RTL.
// Pulled in by the modules that check their own pipeline and counters.
`ifndef KEYED_BYTE_STREAM_DECRYPT_DEFINES_SVH
`define KEYED_BYTE_STREAM_DECRYPT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define KBSD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define KBSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kbsd_pkg.sv
// Shared types and constants of the keyed byte stream decrypt block.
// No dependencies; used by the interfaces and all modules except kbsd_ram.
package kbsd_pkg;

  localparam int KEY_BYTES  = 512;
  localparam int HALF_BYTES = KEY_BYTES / 2;
  localparam int KEY_AW     = $clog2(KEY_BYTES);
  localparam int ROW_AW     = $clog2(HALF_BYTES);
  localparam int NIB_W      = 4;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  typedef struct packed {
    logic              func;
    logic [KEY_AW-1:0] key_index;
    logic [7:0]        key_value;
    logic [7:0]        cipher_byte;
    logic              restart;
  } kbsd_cmd_t;

  typedef struct packed {
    logic [7:0] plain_byte;
  } kbsd_res_t;

  // Selector fetch plan for one data byte: key row in the upper half and
  // which nibble of it, plus the key position used for the lower half.
  typedef struct packed {
    logic [ROW_AW-1:0] sel_a_row;
    logic              sel_a_lo;
    logic [ROW_AW-1:0] sel_b_row;
    logic              sel_b_lo;
    logic [ROW_AW-1:0] key_pos;
  } kbsd_sel_t;

endpackage

// File: rtl/kbsd_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on kbsd_pkg for the payload types.
interface kbsd_cmd_if
  import kbsd_pkg::*;
  ();
  logic      valid;
  logic      ready;
  kbsd_cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kbsd_res_if
  import kbsd_pkg::*;
  ();
  logic      valid;
  logic      ready;
  kbsd_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/kbsd_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// Read returns the old contents when a write hits the same address.
module kbsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/kbsd_addr.sv
// Position counters and selector address generation.
// Depends on kbsd_pkg; checks use the block's assertion macros.
`include "keyed_byte_stream_decrypt_defines.svh"

module kbsd_addr
  import kbsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic      restart,
  output kbsd_sel_t plan
);

  logic [KEY_AW-1:0] sel_pos, sel_pos_next;
  logic [ROW_AW-1:0] key_pos, key_pos_next;
  logic [KEY_AW-1:0] shift_count, shift_count_next;

  logic [KEY_AW-1:0] sp0, sp1, sc0, sel_a, sel_b;
  logic [ROW_AW-1:0] kp0;

  // Step the selector position; wrap to zero at KEY_BYTES - shift.
  function automatic logic [KEY_AW-1:0] adv_sel(input logic [KEY_AW-1:0] sp,
                                                input logic [KEY_AW-1:0] sc);
    logic [KEY_AW:0] sum;
    sum = {1'b0, sp} + {1'b0, sc} + (KEY_AW+1)'(1);
    return (sum >= (KEY_AW+1)'(KEY_BYTES)) ? '0 : sp + KEY_AW'(1);
  endfunction

  always_comb begin
    sp0   = restart ? '0 : sel_pos;
    sc0   = restart ? '0 : shift_count;
    kp0   = restart ? '0 : key_pos;
    sel_a = sp0 + sc0;
    sp1   = adv_sel(sp0, sc0);
    sel_b = sp1 + sc0;
    sel_pos_next = adv_sel(sp1, sc0);
    key_pos_next = kp0 + ROW_AW'(1);
    shift_count_next = (kp0 == '1) ? sc0 + KEY_AW'(1) : sc0;

    plan.sel_a_row = sel_a[KEY_AW-1:1];
    plan.sel_a_lo  = sel_a[0];
    plan.sel_b_row = sel_b[KEY_AW-1:1];
    plan.sel_b_lo  = sel_b[0];
    plan.key_pos   = kp0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_pos     <= '0;
      key_pos     <= '0;
      shift_count <= '0;
    end else if (step) begin
      sel_pos     <= sel_pos_next;
      key_pos     <= key_pos_next;
      shift_count <= shift_count_next;
    end
  end

  `KBSD_ASSERT_NEXT(a_shift_on_wrap, clk, rst, step && !restart && (key_pos == '1),
    (key_pos == '0) && (shift_count == $past(shift_count) + KEY_AW'(1)),
    "shift count did not follow key position wrap")
  `KBSD_ASSERT_NEXT(a_restart_clears, clk, rst, step && restart,
    (key_pos == ROW_AW'(1)) && (shift_count == '0),
    "restart did not clear the position counters")

endmodule

// File: rtl/kbsd_calc.sv
// Formula datapath: product stage, combine stage and output register.
// Depends on kbsd_pkg and the result channel interface.
`include "keyed_byte_stream_decrypt_defines.svh"

module kbsd_calc
  import kbsd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              v2,
  input  logic [7:0]        c2,
  input  logic [NIB_W-1:0]  code2,
  input  logic [7:0]        k2,
  input  logic [7:0]        j2,
  output logic              en2,
  kbsd_res_if.source        result
);

  typedef enum logic [NIB_W-1:0] {
    F_SUB_KPJ   = 4'd0,  F_SUB_KMJ   = 4'd1,  F_SUB_KJ    = 4'd2,  F_ADD_KJ    = 4'd3,
    F_ADD_KPJ   = 4'd4,  F_ADD_KMJ   = 4'd5,  F_SUB_KKPJ  = 4'd6,  F_SUB_KKMJ  = 4'd7,
    F_SUB_KPJJ  = 4'd8,  F_SUB_KMJJ  = 4'd9,  F_SUB_KKPJJ = 4'd10, F_SUB_KKMJJ = 4'd11,
    F_SUB_KJPK  = 4'd12, F_SUB_KJMK  = 4'd13, F_SUB_KJPJJ = 4'd14, F_SUB_KJMJJ = 4'd15
  } formula_t;

  localparam logic [7:0] CLASH_ADJ = 8'd32;

  logic              v3, en3;
  logic [7:0]        c3, k3, j3, kj3, kk3, jj3;
  formula_t          code3;
  logic [15:0]       kj_w, kk_w, jj_w;
  logic [7:0]        d, p, p_fix;
  logic              add;

  assign en3 = !result.valid || result.ready;
  assign en2 = !v3 || en3;

  assign kj_w = k2 * j2;
  assign kk_w = k2 * k2;
  assign jj_w = j2 * j2;

  always_comb begin
    add = 1'b0;
    unique case (code3)
      F_SUB_KPJ:   d = k3 + j3;
      F_SUB_KMJ:   d = k3 - j3;
      F_SUB_KJ:    d = kj3;
      F_ADD_KJ:    begin d = kj3;     add = 1'b1; end
      F_ADD_KPJ:   begin d = k3 + j3; add = 1'b1; end
      F_ADD_KMJ:   begin d = k3 - j3; add = 1'b1; end
      F_SUB_KKPJ:  d = kk3 + j3;
      F_SUB_KKMJ:  d = kk3 - j3;
      F_SUB_KPJJ:  d = k3 + jj3;
      F_SUB_KMJJ:  d = k3 - jj3;
      F_SUB_KKPJJ: d = kk3 + jj3;
      F_SUB_KKMJJ: d = kk3 - jj3;
      F_SUB_KJPK:  d = kj3 + k3;
      F_SUB_KJMK:  d = kj3 - k3;
      F_SUB_KJPJJ: d = kj3 + jj3;
      F_SUB_KJMJJ: d = kj3 - jj3;
    endcase
    p = add ? c3 + d : c3 - d;
    // Never pass the cipher byte through unchanged.
    p_fix = (p == c3) ? p - CLASH_ADJ : p;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3           <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (en2) begin
        v3 <= v2;
      end
      if (en3) begin
        result.valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v2) begin
      c3    <= c2;
      code3 <= formula_t'(code2);
      k3    <= k2;
      j3    <= j2;
      kj3   <= kj_w[7:0];
      kk3   <= kk_w[7:0];
      jj3   <= jj_w[7:0];
    end
    if (en3 && v3) begin
      result.data.plain_byte <= p_fix;
    end
  end

  `KBSD_ASSERT_NEXT(a_combine_to_out, clk, rst, v3 && en3, result.valid,
    "combine stage result lost on its way to the output register")

endmodule

// File: rtl/keyed_byte_stream_decrypt.sv
// Top level of the keyed byte stream decrypt block.
// Depends on kbsd_pkg, kbsd_ifs, kbsd_ram, kbsd_addr and kbsd_calc.
//
//   channel  | dir | payload                                          | accepted when
//   ---------+-----+--------------------------------------------------+-------------------
//   cmd      | in  | func, key_index, key_value, cipher_byte, restart | valid && ready
//   result   | out | plain_byte                                       | valid && ready
//
// One request per cycle unless stalled; a result passes stages 1-3 and the output register.
// Key loads write the key RAM at the accepting edge and give no result.
// The key table is split in two RAMs: the upper half (selectors) is read at accept,
// the lower half (key bytes) as stage 1 moves on, once the second selector is known.
// Each stage holds when the one after it is full and stalled; reset clears all
// counters and stage valid bits, and the key RAM keeps whatever it held.
`include "keyed_byte_stream_decrypt_defines.svh"

module keyed_byte_stream_decrypt
  import kbsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kbsd_cmd_if.sink   cmd,
  kbsd_res_if.source result
);

  logic              acc, acc_load, acc_data;
  logic              en1, en2;
  kbsd_sel_t         plan;

  // Stage 1: selector rows are being read.
  logic              v1, a_lo1, b_lo1;
  logic [7:0]        c1;
  logic [ROW_AW-1:0] kp1;

  // Stage 2: key bytes are being read.
  logic              v2;
  logic [7:0]        c2;
  logic [NIB_W-1:0]  code2, sel2;

  logic [7:0]        up_a, up_b, lo_j, lo_k;

  // Take a request whenever stage 1 is empty or moving on.
  assign en1       = !v1 || (!v2 || en2);
  assign cmd.ready = en1;
  assign acc       = cmd.valid && cmd.ready;
  assign acc_load  = acc && (cmd.data.func == FUNC_LOAD);
  assign acc_data  = acc && (cmd.data.func == FUNC_DECRYPT);

  kbsd_addr u_addr (
    .clk     (clk),
    .rst     (rst),
    .step    (acc_data),
    .restart (cmd.data.restart),
    .plan    (plan)
  );

  // Upper half: selector nibbles. Written by loads, read at accept.
  kbsd_ram #(.WIDTH(8), .DEPTH(HALF_BYTES)) u_sel_ram (
    .clk     (clk),
    .we      (acc_load && cmd.data.key_index[KEY_AW-1]),
    .waddr   (cmd.data.key_index[ROW_AW-1:0]),
    .wdata   (cmd.data.key_value),
    .re_a    (acc_data),
    .raddr_a (plan.sel_a_row),
    .rdata_a (up_a),
    .re_b    (acc_data),
    .raddr_b (plan.sel_b_row),
    .rdata_b (up_b)
  );

  // Pick the second selector nibble; it picks j within the key position's page.
  assign sel2 = b_lo1 ? up_b[NIB_W-1:0] : up_b[7:NIB_W];

  // Lower half: key bytes. A load taken on the same edge as a read here is a later
  // request, so the read returning the old contents keeps request order.
  kbsd_ram #(.WIDTH(8), .DEPTH(HALF_BYTES)) u_key_ram (
    .clk     (clk),
    .we      (acc_load && !cmd.data.key_index[KEY_AW-1]),
    .waddr   (cmd.data.key_index[ROW_AW-1:0]),
    .wdata   (cmd.data.key_value),
    .re_a    (v1 && en1),
    .raddr_a ({kp1[ROW_AW-1:NIB_W], sel2}),
    .rdata_a (lo_j),
    .re_b    (v1 && en1),
    .raddr_b (kp1),
    .rdata_b (lo_k)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= acc_data;
      end
      if (!v2 || en2) begin
        v2 <= v1;
      end
    end
  end

  // Payload: capture with the data request, advance with the stage.
  always_ff @(posedge clk) begin
    if (acc_data) begin
      c1    <= cmd.data.cipher_byte;
      a_lo1 <= plan.sel_a_lo;
      b_lo1 <= plan.sel_b_lo;
      kp1   <= plan.key_pos;
    end
    if (v1 && en1) begin
      c2    <= c1;
      code2 <= a_lo1 ? up_a[NIB_W-1:0] : up_a[7:NIB_W];
    end
  end

  kbsd_calc u_calc (
    .clk    (clk),
    .rst    (rst),
    .v2     (v2),
    .c2     (c2),
    .code2  (code2),
    .k2     (lo_k),
    .j2     (lo_j),
    .en2    (en2),
    .result (result)
  );

  `KBSD_ASSERT_NEXT(a_take_fills_s1, clk, rst, acc_data, v1,
    "accepted data byte did not enter stage 1")
  `KBSD_ASSERT_NEXT(a_s1_hold, clk, rst, v1 && !en1,
    v1 && $stable(c1) && $stable(kp1), "stalled stage 1 lost its contents")
  `KBSD_ASSERT_NEXT(a_s2_hold, clk, rst, v2 && !en2,
    v2 && $stable(code2) && $stable(lo_k) && $stable(lo_j),
    "stalled stage 2 lost its contents")

endmodule
